@@ design/sliding_window_event_rate_meter_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding window event rate meter: assertion macros
// Shared same-cycle and next-cycle implication assertion forms.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_RATE_METER_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_RATE_METER_DEFINES_SVH

// same-cycle implication
`define SWRM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWRM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/swrm_pkg.sv @@
// ----------------------------------------------------------------------------
// swrm_pkg
// Types and constants of the sliding window event rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package swrm_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = RING_AW + 1;
    localparam int KEY_SLOTS  = 256;
    localparam int KEY_AW     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    // 60000 ms per minute times 256 for UQ16.8
    localparam logic [23:0] RATE_SCALE   = 24'd15360000;
    localparam logic [23:0] RATE_MAX     = 24'hFFFFFF;
    localparam logic [31:0] MS_PER_SEC   = 32'd1000;
    // floor(x / 1000) == (x * SEC_RECIP) >> 38 for any 32-bit x
    localparam logic [31:0] SEC_RECIP    = 32'd274877907;
    localparam logic [31:0] CNT_MAX      = 32'hFFFFFFFF;
    localparam logic [21:0] WINDOW_RESET = 22'd60000;
    localparam logic [15:0] REPEAT_RESET = 16'd100;

    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_STOP      = 3'd1,
        MODE_ACTION    = 3'd2,
        MODE_QUERY     = 3'd3,
        MODE_KEY_READ  = 3'd4
    } mode_t;

    typedef enum logic {
        CFG_WINDOW = 1'b0,
        CFG_REPEAT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DSEL_CUR  = 2'd0,
        DSEL_EFF  = 2'd1,
        DSEL_AVG  = 2'd2
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT_KEY,
        ST_EV_RD,
        ST_EV_CMP,
        ST_Q_SETUP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_KEY_RD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_CHK,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] mul_a;
        logic [23:0] mul_b;
        logic [31:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

@@ design/swrm_ram.sv @@
// ----------------------------------------------------------------------------
// swrm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/swrm_div.sv @@
// ----------------------------------------------------------------------------
// swrm_div
// Computes min(a * b / d, 0xFFFFFF), zero for d == 0, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire swrm_pkg::div_req_t req,
    output logic                  done,
    output logic      [23:0]      quot
);

    import swrm_pkg::*;

    div_state_t  state_reg, state_next;
    logic [31:0] a_reg, d_reg;
    logic [23:0] b_reg;
    logic [55:0] prod_reg;
    logic [31:0] rem_reg;
    logic [23:0] low_reg;
    logic [23:0] q_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, low_reg[23]};
    assign ge     = rem_sh >= {1'b0, d_reg};
    assign quot   = q_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (req.start) state_next = DIV_MUL;
            DIV_MUL:  state_next = DIV_CHK;
            DIV_CHK:
            begin
                if (d_reg == 32'd0 || prod_reg[55:24] >= d_reg)
                    state_next = DIV_DONE;
                else
                    state_next = DIV_RUN;
            end
            DIV_RUN:  if (cnt_reg == 5'd0) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == DIV_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DIV_IDLE:
            begin
                a_reg <= req.mul_a;
                b_reg <= req.mul_b;
                d_reg <= req.divisor;
            end
            DIV_MUL:
            begin
                prod_reg <= 56'(a_reg) * 56'(b_reg);
            end
            DIV_CHK:
            begin
                // quotient fits 24 bits iff top part is below the divisor
                rem_reg <= prod_reg[55:24];
                low_reg <= prod_reg[23:0];
                cnt_reg <= 5'd23;
                if (d_reg == 32'd0)
                    q_reg <= 24'd0;
                else
                    q_reg <= RATE_MAX;
            end
            DIV_RUN:
            begin
                rem_reg <= ge ? 32'(rem_sh - {1'b0, d_reg}) : rem_sh[31:0];
                low_reg <= {low_reg[22:0], 1'b0};
                q_reg   <= {q_reg[22:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            DIV_DONE: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ design/sliding_window_event_rate_meter.sv @@
// Start and stop take effect on acceptance; key read goes through ST_KEY_RD; an action
//   writes its key count, then evicts old entries (both rings are walked together).
// Query: evicts old entries while tracking, then runs three bit-serial
//   divides (two windowed rates, average); seconds use a reciprocal multiply.
// One item in flight; a new item is taken while a result waits in the output.
// Reset: control state cleared at once; key counts read as zero via valid bits.
// ----------------------------------------------------------------------------
// sliding_window_event_rate_meter
// Session action rate meter with windowed rings, per-key counts and stats.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_event_rate_meter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] now_ms,
    input  wire logic [15:0] action_id,
    input  wire logic [15:0] age_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tracking,
    output logic [31:0]      total_actions,
    output logic [23:0]      current_rate,
    output logic [23:0]      current_effective_rate,
    output logic [23:0]      average_rate,
    output logic [23:0]      peak_rate,
    output logic [22:0]      session_seconds,
    output logic [31:0]      key_count,
    output logic             overflow,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [21:0] cfg_data
);

    import swrm_pkg::*;

    state_t state_reg, state_next;

    logic [21:0]        window_reg;
    logic [15:0]        repeat_reg;
    logic [RING_AW-1:0] a_head_reg, e_head_reg;
    logic [FILL_W-1:0]  a_fill_reg, e_fill_reg;
    logic [KEY_SLOTS-1:0] key_valid_reg;
    logic [31:0]        total_reg;
    logic [23:0]        peak_reg;
    logic [15:0]        last_id_reg;
    logic               last_id_valid_reg;
    logic [31:0]        last_time_reg;
    logic [31:0]        begin_reg, finish_reg;
    logic               active_reg, ever_reg, lost_reg;
    logic [1:0]         div_idx_reg;
    logic               out_valid_reg;

    logic [2:0]  mode_reg;
    logic [31:0] now_reg, cutoff_reg;
    logic [15:0] id_reg;
    logic        id_ok_reg;
    logic [31:0] elapsed_reg, span_reg;
    logic [23:0] res_cur_reg, res_eff_reg, res_avg_reg;
    logic [22:0] res_sec_reg;
    logic [31:0] res_key_reg;

    logic        tracking_reg, overflow_reg;
    logic [31:0] total_out_reg, key_out_reg;
    logic [23:0] cur_out_reg, eff_out_reg, avg_out_reg, peak_out_reg;
    logic [22:0] sec_out_reg;

    logic        in_fire, out_fire, act_go, e_push, key_we, out_load;
    logic [31:0] ev, cutoff_c, q_t, elapsed_c, span_c;
    logic [32:0] ev_diff;
    logic        is_rep, in_id_ok;
    logic        a_full, e_full, a_go, e_go;
    logic [RING_AW-1:0] a_waddr, e_waddr;
    logic [31:0] a_rdata, e_rdata, key_rdata, key_base, key_inc;
    logic [63:0] sec_prod;
    div_req_t    div_req;
    logic        div_done;
    logic [23:0] div_q;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign cfg_ready = (state_reg == ST_IDLE);

    assign ev       = (now_ms > {16'd0, age_ms}) ? now_ms - {16'd0, age_ms} : 32'd0;
    assign cutoff_c = (now_ms > {10'd0, window_reg}) ? now_ms - {10'd0, window_reg}
                                                     : 32'd0;
    assign ev_diff  = {1'b0, ev} - {1'b0, last_time_reg};
    assign is_rep   = last_id_valid_reg && (action_id == last_id_reg) &&
                      ($signed(ev_diff) < $signed({17'd0, repeat_reg}));
    assign in_id_ok = {1'b0, action_id} < 17'(KEY_SLOTS);

    assign act_go = in_fire && (mode == MODE_ACTION) && active_reg;
    assign e_push = act_go && !is_rep;

    // a full ring overwrites its oldest entry
    assign a_full  = (a_fill_reg == FILL_W'(RING_DEPTH));
    assign e_full  = (e_fill_reg == FILL_W'(RING_DEPTH));
    assign a_waddr = a_full ? a_head_reg : a_head_reg + a_fill_reg[RING_AW-1:0];
    assign e_waddr = e_full ? e_head_reg : e_head_reg + e_fill_reg[RING_AW-1:0];

    assign a_go = (a_fill_reg != '0) && (a_rdata < cutoff_reg);
    assign e_go = (e_fill_reg != '0) && (e_rdata < cutoff_reg);

    assign key_base = key_valid_reg[id_reg[KEY_AW-1:0]] ? key_rdata : 32'd0;
    assign key_inc  = (key_base == CNT_MAX) ? key_base : key_base + 32'd1;

    assign q_t       = active_reg ? now_reg : finish_reg;
    assign elapsed_c = (q_t > begin_reg) ? q_t - begin_reg : 32'd0;
    assign span_c    = (elapsed_c < {10'd0, window_reg}) ? elapsed_c
                                                         : {10'd0, window_reg};

    assign sec_prod = 64'(elapsed_reg) * 64'(SEC_RECIP);

    swrm_ram #(.DEPTH(RING_DEPTH), .WIDTH(32)) u_action_ring (
        .clk   (clk),
        .we    (act_go),
        .waddr (a_waddr),
        .wdata (ev),
        .raddr (a_head_reg),
        .rdata (a_rdata)
    );

    swrm_ram #(.DEPTH(RING_DEPTH), .WIDTH(32)) u_effective_ring (
        .clk   (clk),
        .we    (e_push),
        .waddr (e_waddr),
        .wdata (ev),
        .raddr (e_head_reg),
        .rdata (e_rdata)
    );

    swrm_ram #(.DEPTH(KEY_SLOTS), .WIDTH(32)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (id_reg[KEY_AW-1:0]),
        .wdata (key_inc),
        .raddr (action_id[KEY_AW-1:0]),
        .rdata (key_rdata)
    );

    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_GO);
        unique case (div_sel_t'(div_idx_reg))
            DSEL_CUR:
            begin
                div_req.mul_a   = 32'(a_fill_reg);
                div_req.mul_b   = RATE_SCALE;
                div_req.divisor = span_reg;
            end
            DSEL_EFF:
            begin
                div_req.mul_a   = 32'(e_fill_reg);
                div_req.mul_b   = RATE_SCALE;
                div_req.divisor = span_reg;
            end
            DSEL_AVG:
            begin
                div_req.mul_a   = total_reg;
                div_req.mul_b   = RATE_SCALE;
                div_req.divisor = elapsed_reg;
            end
            default:
            begin
                div_req.mul_a   = elapsed_reg;
                div_req.mul_b   = 24'd1;
                div_req.divisor = MS_PER_SEC;
            end
        endcase
    end

    swrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority case (mode)
                        MODE_ACTION:   state_next = active_reg ? ST_ACT_KEY : ST_IDLE;
                        MODE_QUERY:    state_next = active_reg ? ST_EV_RD : ST_Q_SETUP;
                        MODE_KEY_READ: state_next = ST_KEY_RD;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACT_KEY: state_next = ST_EV_RD;
            ST_EV_RD:   state_next = ST_EV_CMP;
            ST_EV_CMP:
            begin
                if (a_go || e_go)
                    state_next = ST_EV_RD;
                else if (mode_reg == MODE_ACTION)
                    state_next = ST_IDLE;
                else
                    state_next = ST_Q_SETUP;
            end
            ST_Q_SETUP: state_next = ever_reg ? ST_DIV_GO : ST_OUT;
            ST_DIV_GO:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (div_idx_reg == DSEL_AVG) ? ST_OUT : ST_DIV_GO;
            end
            ST_KEY_RD:  state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        key_we   = (state_reg == ST_ACT_KEY) && id_ok_reg;
        out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg        <= WINDOW_RESET;
            repeat_reg        <= REPEAT_RESET;
            a_head_reg        <= '0;
            a_fill_reg        <= '0;
            e_head_reg        <= '0;
            e_fill_reg        <= '0;
            key_valid_reg     <= '0;
            total_reg         <= '0;
            peak_reg          <= '0;
            last_id_reg       <= '0;
            last_id_valid_reg <= 1'b0;
            last_time_reg     <= '0;
            begin_reg         <= '0;
            finish_reg        <= '0;
            active_reg        <= 1'b0;
            ever_reg          <= 1'b0;
            lost_reg          <= 1'b0;
            div_idx_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WINDOW: window_reg <= cfg_data;
                    CFG_REPEAT: repeat_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_fire && mode == MODE_START)
            begin
                active_reg        <= 1'b1;
                ever_reg          <= 1'b1;
                begin_reg         <= now_ms;
                finish_reg        <= now_ms;
                a_head_reg        <= '0;
                a_fill_reg        <= '0;
                e_head_reg        <= '0;
                e_fill_reg        <= '0;
                key_valid_reg     <= '0;
                total_reg         <= '0;
                peak_reg          <= '0;
                last_id_reg       <= '0;
                last_id_valid_reg <= 1'b0;
                last_time_reg     <= '0;
            end

            if (in_fire && mode == MODE_STOP && active_reg)
            begin
                active_reg <= 1'b0;
                finish_reg <= now_ms;
            end

            if (act_go)
            begin
                if (a_full)
                    a_head_reg <= a_head_reg + 1'b1;
                else
                    a_fill_reg <= a_fill_reg + 1'b1;
                if (e_push)
                begin
                    if (e_full)
                        e_head_reg <= e_head_reg + 1'b1;
                    else
                        e_fill_reg <= e_fill_reg + 1'b1;
                end
                if (a_full || (e_push && e_full))
                    lost_reg <= 1'b1;
                if (total_reg != CNT_MAX)
                    total_reg <= total_reg + 32'd1;
                last_id_reg       <= action_id;
                last_id_valid_reg <= 1'b1;
                last_time_reg     <= ev;
            end

            if (key_we)
                key_valid_reg[id_reg[KEY_AW-1:0]] <= 1'b1;

            if (state_reg == ST_EV_CMP)
            begin
                if (a_go)
                begin
                    a_head_reg <= a_head_reg + 1'b1;
                    a_fill_reg <= a_fill_reg - 1'b1;
                end
                if (e_go)
                begin
                    e_head_reg <= e_head_reg + 1'b1;
                    e_fill_reg <= e_fill_reg - 1'b1;
                end
            end

            if (state_reg == ST_Q_SETUP)
                div_idx_reg <= '0;

            if (state_reg == ST_DIV_WAIT && div_done)
            begin
                div_idx_reg <= div_idx_reg + 2'd1;
                if (div_idx_reg == DSEL_CUR && active_reg && div_q > peak_reg)
                    peak_reg <= div_q;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg    <= mode;
            now_reg     <= now_ms;
            id_reg      <= action_id;
            id_ok_reg   <= in_id_ok;
            cutoff_reg  <= cutoff_c;
            res_cur_reg <= '0;
            res_eff_reg <= '0;
            res_avg_reg <= '0;
            res_sec_reg <= '0;
            res_key_reg <= '0;
        end

        if (state_reg == ST_Q_SETUP)
        begin
            elapsed_reg <= elapsed_c;
            span_reg    <= span_c;
        end

        if (state_reg == ST_DIV_GO && div_idx_reg == DSEL_CUR)
            res_sec_reg <= sec_prod[60:38];

        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            unique case (div_sel_t'(div_idx_reg))
                DSEL_CUR:  res_cur_reg <= div_q;
                DSEL_EFF:  res_eff_reg <= div_q;
                DSEL_AVG:  res_avg_reg <= div_q;
                default: ;
            endcase
        end

        if (state_reg == ST_KEY_RD)
            res_key_reg <= (id_ok_reg && key_valid_reg[id_reg[KEY_AW-1:0]]) ? key_rdata
                                                                             : 32'd0;

        if (out_load)
        begin
            tracking_reg  <= active_reg;
            total_out_reg <= total_reg;
            cur_out_reg   <= res_cur_reg;
            eff_out_reg   <= res_eff_reg;
            avg_out_reg   <= res_avg_reg;
            peak_out_reg  <= (mode_reg == MODE_QUERY) ? peak_reg : 24'd0;
            sec_out_reg   <= res_sec_reg;
            key_out_reg   <= res_key_reg;
            overflow_reg  <= lost_reg;
        end
    end

    assign out_valid              = out_valid_reg;
    assign tracking               = tracking_reg;
    assign total_actions          = total_out_reg;
    assign current_rate           = cur_out_reg;
    assign current_effective_rate = eff_out_reg;
    assign average_rate           = avg_out_reg;
    assign peak_rate              = peak_out_reg;
    assign session_seconds        = sec_out_reg;
    assign key_count              = key_out_reg;
    assign overflow               = overflow_reg;

endmodule

`default_nettype wire

@@ design/swrm_checker.sv @@
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks of the rate meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_event_rate_meter_defines.svh"

module swrm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        tracking,
    input wire logic [23:0] current_rate,
    input wire logic [23:0] peak_rate,
    input wire logic [22:0] session_seconds,
    input wire logic [31:0] key_count,
    input wire logic        overflow
);

    logic seen_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_ovf_reg <= 1'b0;
        else if (out_valid && out_ready && overflow)
            seen_ovf_reg <= 1'b1;
    end

    `SWRM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(current_rate), "result changed while stalled")

    `SWRM_ASSERT_IMP(a_ovf_sticky, clk, rst_n, out_valid && seen_ovf_reg, overflow, "overflow flag cleared")

    `SWRM_ASSERT_IMP(a_peak_ge_cur, clk, rst_n, out_valid && tracking, peak_rate >= current_rate, "peak below current rate")

    `SWRM_ASSERT_IMP(a_key_only, clk, rst_n, out_valid && key_count != 32'd0, current_rate == 24'd0 && session_seconds == 23'd0, "key read carries stats")

endmodule

bind sliding_window_event_rate_meter swrm_checker u_swrm_checker (.*);

`default_nettype wire
